>>> hw/rtl/pfcg_pkg.sv
`timescale 1ns / 1ps

package pfcg_pkg;

  // Coordinate width of cursor, row and emitted positions.
  localparam int unsigned COORD_BITS = 12;

  // Glyph geometry.
  localparam int unsigned ROWS     = 9;
  localparam int unsigned MAX_COLS = 7;
  localparam int unsigned COL_BITS = $clog2(MAX_COLS + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROWS-1:0]       pix_t;

  // ROM lookup result: width 0 and supported 0 for codes without a glyph.
  typedef struct packed {
    logic supported;
    col_t width;
    pix_t bits;
  } glyph_t;

endpackage

>>> hw/rtl/pfcg_glyph_rom.sv
`timescale 1ns / 1ps

// Glyph ROM: folds lower case to upper case, returns glyph width and the
// pixel column selected by col_i (zero past the glyph's last column).
module pfcg_glyph_rom (
  input  logic [7:0]      code_i,
  input  pfcg_pkg::col_t  col_i,
  output pfcg_pkg::glyph_t glyph_o
);

  logic [7:0]           norm;
  pfcg_pkg::col_t       width;
  pfcg_pkg::pix_t       cols [8];

  always_comb begin
    norm = code_i;
    if (code_i inside {[8'h61:8'h7a]}) begin
      norm = code_i - 8'h20;
    end
  end

  always_comb begin
    width = '0;
    cols  = '{default: '0};
    case (norm)
      8'h20: width = 3'd2; // space, two blank columns
      8'h28: begin width = 3'd2; cols = '{9'h0fe, 9'h101, 0, 0, 0, 0, 0, 0}; end
      8'h29: begin width = 3'd2; cols = '{9'h101, 9'h0fe, 0, 0, 0, 0, 0, 0}; end
      8'h2d: begin width = 3'd3; cols = '{9'h010, 9'h010, 9'h010, 0, 0, 0, 0, 0}; end
      8'h30: begin
        width = 3'd6; cols = '{9'h0fe, 9'h101, 9'h101, 9'h101, 9'h1f1, 9'h0fe, 0, 0};
      end
      8'h31: begin width = 3'd2; cols = '{9'h01f, 9'h1ff, 0, 0, 0, 0, 0, 0}; end
      8'h32: begin
        width = 3'd6; cols = '{9'h08e, 9'h11f, 9'h111, 9'h111, 9'h111, 9'h0e1, 0, 0};
      end
      8'h33: begin
        width = 3'd6; cols = '{9'h082, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h0fe, 0, 0};
      end
      8'h34: begin
        width = 3'd6; cols = '{9'h1f8, 9'h004, 9'h004, 9'h007, 9'h01f, 9'h004, 0, 0};
      end
      8'h35: begin
        width = 3'd6; cols = '{9'h0e2, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h10e, 0, 0};
      end
      8'h36: begin
        width = 3'd6; cols = '{9'h0fe, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h08e, 0, 0};
      end
      8'h37: begin
        width = 3'd6; cols = '{9'h100, 9'h100, 9'h100, 9'h100, 9'h11f, 9'h0ff, 0, 0};
      end
      8'h38: begin
        width = 3'd6; cols = '{9'h0fe, 9'h1f1, 9'h111, 9'h111, 9'h111, 9'h0fe, 0, 0};
      end
      8'h39: begin
        width = 3'd6; cols = '{9'h0e0, 9'h110, 9'h110, 9'h110, 9'h11f, 9'h0ff, 0, 0};
      end
      8'h3a: begin width = 3'd1; cols = '{9'h028, 0, 0, 0, 0, 0, 0, 0}; end
      8'h3d: begin width = 3'd3; cols = '{9'h028, 9'h028, 9'h028, 0, 0, 0, 0, 0}; end
      8'h41: begin
        width = 3'd6; cols = '{9'h01f, 9'h0ff, 9'h110, 9'h110, 9'h0f0, 9'h01f, 0, 0};
      end
      8'h42: begin
        width = 3'd6; cols = '{9'h0fe, 9'h11f, 9'h111, 9'h111, 9'h0f1, 9'h00e, 0, 0};
      end
      8'h43: begin
        width = 3'd5; cols = '{9'h0fe, 9'h11f, 9'h101, 9'h101, 9'h101, 0, 0, 0};
      end
      8'h44: begin
        width = 3'd6; cols = '{9'h0fe, 9'h11f, 9'h101, 9'h101, 9'h101, 9'h0fe, 0, 0};
      end
      8'h45: begin
        width = 3'd6; cols = '{9'h0fe, 9'h11f, 9'h111, 9'h111, 9'h111, 9'h101, 0, 0};
      end
      8'h46: begin
        width = 3'd6; cols = '{9'h0ff, 9'h11f, 9'h110, 9'h110, 9'h110, 9'h100, 0, 0};
      end
      8'h47: begin
        width = 3'd6; cols = '{9'h0fe, 9'h101, 9'h101, 9'h111, 9'h11f, 9'h0de, 0, 0};
      end
      8'h48: begin
        width = 3'd6; cols = '{9'h1ff, 9'h01f, 9'h010, 9'h010, 9'h010, 9'h1ff, 0, 0};
      end
      8'h49: begin width = 3'd2; cols = '{9'h1ff, 9'h00f, 0, 0, 0, 0, 0, 0}; end
      8'h4a: begin
        width = 3'd5; cols = '{9'h001, 9'h001, 9'h001, 9'h01f, 9'h1fe, 0, 0, 0};
      end
      8'h4b: begin
        width = 3'd6; cols = '{9'h1ff, 9'h01f, 9'h010, 9'h1f0, 9'h010, 9'h00f, 0, 0};
      end
      8'h4c: begin
        width = 3'd6; cols = '{9'h1fe, 9'h01f, 9'h001, 9'h001, 9'h001, 9'h001, 0, 0};
      end
      8'h4d: begin
        width = 3'd7;
        cols = '{9'h0ff, 9'h10f, 9'h100, 9'h0ff, 9'h100, 9'h100, 9'h0ff, 0};
      end
      8'h4e: begin
        width = 3'd6; cols = '{9'h0ff, 9'h10f, 9'h100, 9'h100, 9'h100, 9'h0ff, 0, 0};
      end
      8'h4f: begin
        width = 3'd6; cols = '{9'h0fe, 9'h101, 9'h101, 9'h101, 9'h1c1, 9'h0fe, 0, 0};
      end
      8'h50: begin
        width = 3'd6; cols = '{9'h1ff, 9'h11f, 9'h110, 9'h110, 9'h110, 9'h0e0, 0, 0};
      end
      8'h51: begin
        width = 3'd6; cols = '{9'h0fe, 9'h101, 9'h101, 9'h101, 9'h10f, 9'h0ff, 0, 0};
      end
      8'h52: begin
        width = 3'd6; cols = '{9'h0ff, 9'h11f, 9'h110, 9'h110, 9'h0f0, 9'h00f, 0, 0};
      end
      8'h53: begin
        width = 3'd6; cols = '{9'h0e6, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h08e, 0, 0};
      end
      8'h54: begin
        width = 3'd7;
        cols = '{9'h100, 9'h100, 9'h100, 9'h1ff, 9'h11f, 9'h100, 9'h100, 0};
      end
      8'h55: begin
        width = 3'd6; cols = '{9'h1fe, 9'h001, 9'h001, 9'h001, 9'h01f, 9'h1fe, 0, 0};
      end
      8'h56: begin
        width = 3'd6; cols = '{9'h1f0, 9'h00e, 9'h001, 9'h001, 9'h1fe, 9'h1f0, 0, 0};
      end
      8'h57: begin
        width = 3'd7;
        cols = '{9'h1fe, 9'h001, 9'h001, 9'h1fe, 9'h001, 9'h01f, 9'h1fe, 0};
      end
      8'h58: begin
        width = 3'd6; cols = '{9'h1c7, 9'h028, 9'h010, 9'h010, 9'h02f, 9'h1c7, 0, 0};
      end
      8'h59: begin
        width = 3'd6; cols = '{9'h1e0, 9'h010, 9'h01f, 9'h01f, 9'h010, 9'h1e0, 0, 0};
      end
      8'h5a: begin
        width = 3'd6; cols = '{9'h10e, 9'h11f, 9'h111, 9'h121, 9'h121, 9'h0c1, 0, 0};
      end
      default: width = '0; // no glyph for this code
    endcase
  end

  assign glyph_o.supported = (width != '0);
  assign glyph_o.width     = width;
  assign glyph_o.bits      = cols[col_i];

endmodule

>>> hw/rtl/proportional_font_column_generator.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake             | Word
// --------+-----+-----------------------+------------------------------------------------
// in      | in  | in_valid_i/in_stall_o | char_code_i, first_char_i, origin_x_i, origin_y_i
// out     | out | out_valid_o/out_stall_i | column_x_o, column_y_o, pixel_bits_o, last_column_o
//
// Sequence: a character of glyph width W (1..7) is accepted, then its columns
//   are issued one per cycle from the glyph ROM, followed by the spacer,
//   while the output is not stalled. A code without a glyph is accepted and emits nothing.
// The column sequencer and the single cursor incrementer drive this sequence.
// Reset clears cursor, row, sequencer and output valid.
// in_stall_o is high while columns are being issued; an out stall freezes
//   the sequencer while the output word is valid, and the output register holds its word.

module proportional_font_column_generator (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_code_i,
  input  logic                   first_char_i,
  input  pfcg_pkg::coord_t       origin_x_i,
  input  pfcg_pkg::coord_t       origin_y_i,
  // output words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pfcg_pkg::coord_t       column_x_o,
  output pfcg_pkg::coord_t       column_y_o,
  output pfcg_pkg::pix_t         pixel_bits_o,
  output logic                   last_column_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic             state_q, state_d;
  logic [7:0]       code_q, code_d;
  pfcg_pkg::col_t   col_q, col_d;
  pfcg_pkg::coord_t cursor_q, cursor_d;
  pfcg_pkg::coord_t row_q, row_d;
  logic             out_valid_q, out_valid_d;

  pfcg_pkg::coord_t column_x_q, column_y_q;
  pfcg_pkg::pix_t   pixel_bits_q;
  logic             last_column_q;

  logic             in_acc;
  logic             adv;       // issue one column this cycle
  logic             is_spacer;
  logic [7:0]       rom_code;
  pfcg_pkg::glyph_t glyph;

  assign in_stall_o = (state_q == StRun);
  assign in_acc     = in_valid_i && !in_stall_o;

  // While idle the ROM looks at the incoming code to get its width; while
  // running it serves the stored code column by column.
  assign rom_code = (state_q == StRun) ? code_q : char_code_i;

  pfcg_glyph_rom u_rom (
    .code_i  (rom_code),
    .col_i   (col_q),
    .glyph_o (glyph)
  );

  assign adv       = (state_q == StRun) && (!out_valid_q || !out_stall_i);
  assign is_spacer = (col_q == glyph.width);

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    col_d       = col_q;
    cursor_d    = cursor_q;
    row_d       = row_q;
    if (in_acc) begin
      if (first_char_i) begin
        cursor_d = origin_x_i;
        row_d    = origin_y_i;
      end
      if (glyph.supported) begin
        state_d = StRun;
        code_d  = char_code_i;
        col_d   = '0;
      end
    end
    if (adv) begin
      // cursor incrementer: cursor moves one column per issued word
      cursor_d = cursor_q + 1'b1;
      col_d    = col_q + 1'b1;
      if (is_spacer) begin
        state_d = StIdle;
      end
    end
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      cursor_q    <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      cursor_q    <= cursor_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    if (adv) begin
      column_x_q    <= cursor_q;
      column_y_q    <= row_q;
      pixel_bits_q  <= is_spacer ? '0 : glyph.bits;
      last_column_q <= is_spacer;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_x_o    = column_x_q;
  assign column_y_o    = column_y_q;
  assign pixel_bits_o  = pixel_bits_q;
  assign last_column_o = last_column_q;

  // column counter never runs past the spacer of the glyph being issued
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (col_q <= glyph.width))
    else $error("column counter past spacer");

  // a supported character starts its run at the first column
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && glyph.supported) |=> (state_q == StRun && col_q == '0))
    else $error("glyph run did not start");

  // cursor sits one past the column just issued
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (cursor_q == pfcg_pkg::coord_t'(column_x_o + 1'b1)))
    else $error("cursor out of step with issued column");

  // spacer words are blank
  a_spacer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_column_o) |-> (pixel_bits_o == '0))
    else $error("spacer column carries pixels");

endmodule

>>> tb/sv/proportional_font_column_generator_test.sv
`timescale 1ns / 1ps

module proportional_font_column_generator_test;

  // Lower case letters sit this far above their upper case glyphs.
  localparam logic [7:0]      CASE_OFFSET = 8'h20;
  localparam pfcg_pkg::pix_t  BLANK       = '0;
  localparam int unsigned CHAR_ITEMS  = 220;
  // Below this many queued characters both sides stop idling.
  localparam int unsigned CALM_DEPTH  = 40;
  // Receiver hold-off that backs the block up into its input.
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned HOLD_AFTER  = 120;
  localparam int unsigned TAIL_CYCLES = 20;

  // Glyph columns, leftmost column in the top slot.
  typedef pfcg_pkg::pix_t [pfcg_pkg::MAX_COLS-1:0] glyph_cols_t;

  typedef struct {
    logic [7:0]       code;
    logic             first;
    pfcg_pkg::coord_t ox;
    pfcg_pkg::coord_t oy;
  } char_word_t;

  typedef struct {
    pfcg_pkg::coord_t x;
    pfcg_pkg::coord_t y;
    pfcg_pkg::pix_t   bits;
    logic             last;
  } column_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [7:0]       char_code_i   = '0;
  logic             first_char_i  = 1'b0;
  pfcg_pkg::coord_t origin_x_i    = '0;
  pfcg_pkg::coord_t origin_y_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  pfcg_pkg::coord_t column_x_o;
  pfcg_pkg::coord_t column_y_o;
  pfcg_pkg::pix_t   pixel_bits_o;
  logic             last_column_o;

  proportional_font_column_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .first_char_i (first_char_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_x_o   (column_x_o),
    .column_y_o   (column_y_o),
    .pixel_bits_o (pixel_bits_o),
    .last_column_o(last_column_o)
  );

  char_word_t       char_queue[$];       // characters still to be offered
  column_t          pending_columns[$];  // columns predicted, not yet seen
  pfcg_pkg::coord_t cursor_pos  = '0;    // predicted x of next column
  pfcg_pkg::coord_t string_row  = '0;    // predicted top y of the string
  int unsigned error_count = 0;
  int unsigned columns_seen = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Font ROM as the block should hold it; width 0 means no glyph.
  function automatic void glyph_lookup(input logic [7:0] code, output int unsigned width,
                                       output glyph_cols_t cols);
    logic [7:0] ch;
    ch = code;
    if (ch >= "a" && ch <= "z") ch = ch - CASE_OFFSET;
    width = 6;
    cols  = '0;
    case (ch)
      " ": begin width = 2; cols = '0; end
      "(": begin width = 2; cols = {9'h0fe, 9'h101, {5{BLANK}}}; end
      ")": begin width = 2; cols = {9'h101, 9'h0fe, {5{BLANK}}}; end
      "-": begin width = 3; cols = {9'h010, 9'h010, 9'h010, {4{BLANK}}}; end
      "0": cols = {9'h0fe, 9'h101, 9'h101, 9'h101, 9'h1f1, 9'h0fe, BLANK};
      "1": begin width = 2; cols = {9'h01f, 9'h1ff, {5{BLANK}}}; end
      "2": cols = {9'h08e, 9'h11f, 9'h111, 9'h111, 9'h111, 9'h0e1, BLANK};
      "3": cols = {9'h082, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h0fe, BLANK};
      "4": cols = {9'h1f8, 9'h004, 9'h004, 9'h007, 9'h01f, 9'h004, BLANK};
      "5": cols = {9'h0e2, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h10e, BLANK};
      "6": cols = {9'h0fe, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h08e, BLANK};
      "7": cols = {9'h100, 9'h100, 9'h100, 9'h100, 9'h11f, 9'h0ff, BLANK};
      "8": cols = {9'h0fe, 9'h1f1, 9'h111, 9'h111, 9'h111, 9'h0fe, BLANK};
      "9": cols = {9'h0e0, 9'h110, 9'h110, 9'h110, 9'h11f, 9'h0ff, BLANK};
      ":": begin width = 1; cols = {9'h028, {6{BLANK}}}; end
      "=": begin width = 3; cols = {9'h028, 9'h028, 9'h028, {4{BLANK}}}; end
      "A": cols = {9'h01f, 9'h0ff, 9'h110, 9'h110, 9'h0f0, 9'h01f, BLANK};
      "B": cols = {9'h0fe, 9'h11f, 9'h111, 9'h111, 9'h0f1, 9'h00e, BLANK};
      "C": begin width = 5; cols = {9'h0fe, 9'h11f, 9'h101, 9'h101, 9'h101, {2{BLANK}}}; end
      "D": cols = {9'h0fe, 9'h11f, 9'h101, 9'h101, 9'h101, 9'h0fe, BLANK};
      "E": cols = {9'h0fe, 9'h11f, 9'h111, 9'h111, 9'h111, 9'h101, BLANK};
      "F": cols = {9'h0ff, 9'h11f, 9'h110, 9'h110, 9'h110, 9'h100, BLANK};
      "G": cols = {9'h0fe, 9'h101, 9'h101, 9'h111, 9'h11f, 9'h0de, BLANK};
      "H": cols = {9'h1ff, 9'h01f, 9'h010, 9'h010, 9'h010, 9'h1ff, BLANK};
      "I": begin width = 2; cols = {9'h1ff, 9'h00f, {5{BLANK}}}; end
      "J": begin width = 5; cols = {9'h001, 9'h001, 9'h001, 9'h01f, 9'h1fe, {2{BLANK}}}; end
      "K": cols = {9'h1ff, 9'h01f, 9'h010, 9'h1f0, 9'h010, 9'h00f, BLANK};
      "L": cols = {9'h1fe, 9'h01f, 9'h001, 9'h001, 9'h001, 9'h001, BLANK};
      "M": begin
        width = 7;
        cols  = {9'h0ff, 9'h10f, 9'h100, 9'h0ff, 9'h100, 9'h100, 9'h0ff};
      end
      "N": cols = {9'h0ff, 9'h10f, 9'h100, 9'h100, 9'h100, 9'h0ff, BLANK};
      "O": cols = {9'h0fe, 9'h101, 9'h101, 9'h101, 9'h1c1, 9'h0fe, BLANK};
      "P": cols = {9'h1ff, 9'h11f, 9'h110, 9'h110, 9'h110, 9'h0e0, BLANK};
      "Q": cols = {9'h0fe, 9'h101, 9'h101, 9'h101, 9'h10f, 9'h0ff, BLANK};
      "R": cols = {9'h0ff, 9'h11f, 9'h110, 9'h110, 9'h0f0, 9'h00f, BLANK};
      "S": cols = {9'h0e6, 9'h111, 9'h111, 9'h111, 9'h11f, 9'h08e, BLANK};
      "T": begin
        width = 7;
        cols  = {9'h100, 9'h100, 9'h100, 9'h1ff, 9'h11f, 9'h100, 9'h100};
      end
      "U": cols = {9'h1fe, 9'h001, 9'h001, 9'h001, 9'h01f, 9'h1fe, BLANK};
      "V": cols = {9'h1f0, 9'h00e, 9'h001, 9'h001, 9'h1fe, 9'h1f0, BLANK};
      "W": begin
        width = 7;
        cols  = {9'h1fe, 9'h001, 9'h001, 9'h1fe, 9'h001, 9'h01f, 9'h1fe};
      end
      "X": cols = {9'h1c7, 9'h028, 9'h010, 9'h010, 9'h02f, 9'h1c7, BLANK};
      "Y": cols = {9'h1e0, 9'h010, 9'h01f, 9'h01f, 9'h010, 9'h1e0, BLANK};
      "Z": cols = {9'h10e, 9'h11f, 9'h111, 9'h121, 9'h121, 9'h0c1, BLANK};
      default: width = 0;
    endcase
  endfunction

  // Expected columns of one accepted character; updates the predicted cursor.
  function automatic void render_char(input char_word_t w);
    int unsigned      width;
    glyph_cols_t      cols;
    pfcg_pkg::coord_t x;
    if (w.first) begin
      cursor_pos = w.ox;
      string_row = w.oy;
    end
    glyph_lookup(w.code, width, cols);
    if (width == 0) return;
    x = cursor_pos;
    for (int i = 0; i < width; i++) begin
      pending_columns.push_back(column_t'{x, string_row, cols[pfcg_pkg::MAX_COLS-1-i], 1'b0});
      x = x + 1'b1;  // wraps at the coordinate width
    end
    pending_columns.push_back(column_t'{x, string_row, BLANK, 1'b1});
    cursor_pos = x + 1'b1;
  endfunction

  function automatic bit calm_tail();
    return char_queue.size() < CALM_DEPTH;
  endfunction

  task automatic add_char(input logic [7:0] code, input logic first,
                          input pfcg_pkg::coord_t ox, input pfcg_pkg::coord_t oy);
    char_queue.push_back(char_word_t'{code, first, ox, oy});
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sender: a word stays on the ports, unchanged, until it is taken. Between
  // words it idles in short random bursts until the tail of the run.
  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        render_char(char_word_t'{char_code_i, first_char_i, origin_x_i, origin_y_i});
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm_tail() && $urandom_range(0, 5) == 0) begin
          gap_left   <= $urandom_range(0, 6);
          in_valid_i <= 1'b0;
        end else if (char_queue.size() != 0) begin
          word = char_queue.pop_front();
          char_code_i  <= word.code;
          first_char_i <= word.first;
          origin_x_i   <= word.ox;
          origin_y_i   <= word.oy;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off once enough columns are through, so the
  // block backs up and stalls its input; otherwise short random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && columns_seen >= HOLD_AFTER) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm_tail() && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Scoreboard: every column taken is matched against the oldest prediction.
  always @(posedge clk_i) begin
    column_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      columns_seen <= columns_seen + 1;
      if (pending_columns.size() == 0) begin
        $display("%0t: unexpected column, expected none, got x=%0h y=%0h bits=%0h last=%0b",
                 $time, column_x_o, column_y_o, pixel_bits_o, last_column_o);
        error_count++;
      end else begin
        want = pending_columns.pop_front();
        check_field("column_x", want.x, column_x_o);
        check_field("column_y", want.y, column_y_o);
        check_field("pixel_bits", want.bits, pixel_bits_o);
        check_field("last_column", want.last, last_column_o);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("proportional_font_column_generator_test: FAIL");
    $finish;
  end

  initial begin
    string            glyph_set;
    logic [7:0]       code;
    pfcg_pkg::coord_t ox;

    glyph_set = " ()-0123456789:=ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    // Directed: cursor from reset, wrap at the right edge, narrow and wide
    // glyphs, lower case folding, codes without a glyph just around the table.
    add_char("A", 1'b0, 12'h000, 12'h000);
    add_char("(", 1'b1, 12'hffe, 12'hfff);
    add_char(")", 1'b0, 12'h000, 12'h000);
    add_char("M", 1'b1, 12'hffc, 12'h800);
    add_char("-", 1'b0, 12'hfff, 12'hfff);
    add_char(":", 1'b0, 12'h000, 12'h000);
    add_char("=", 1'b0, 12'h000, 12'h000);
    add_char(" ", 1'b0, 12'h000, 12'h000);
    add_char("1", 1'b0, 12'h000, 12'h000);
    add_char("m", 1'b0, 12'h000, 12'h000);
    add_char("z", 1'b0, 12'h000, 12'h000);
    add_char("W", 1'b0, 12'h000, 12'h000);
    add_char(8'h00, 1'b0, 12'hfff, 12'hfff);
    // No glyph, but the origin is still taken.
    add_char(8'hff, 1'b1, 12'h555, 12'haaa);
    add_char("0", 1'b0, 12'h000, 12'h000);
    add_char(8'h1f, 1'b0, 12'h000, 12'h000);
    add_char(8'h5b, 1'b0, 12'h000, 12'h000);
    add_char(8'h60, 1'b0, 12'h000, 12'h000);
    add_char(8'h7b, 1'b0, 12'h000, 12'h000);
    add_char("!", 1'b0, 12'h000, 12'h000);
    add_char("a", 1'b1, 12'h000, 12'h000);
    add_char("T", 1'b0, 12'h000, 12'h000);
    add_char("I", 1'b0, 12'h000, 12'h000);

    // Random: mostly renderable text with random restarts, some raw bytes.
    while (char_queue.size() < CHAR_ITEMS) begin
      if ($urandom_range(0, 9) < 8) code = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
      else code = 8'($urandom_range(0, 255));
      ox = ($urandom_range(0, 3) == 0) ? pfcg_pkg::coord_t'($urandom_range(4088, 4095))
                                       : pfcg_pkg::coord_t'($urandom_range(0, 4095));
      add_char(code, $urandom_range(0, 5) == 0, ox,
               pfcg_pkg::coord_t'($urandom_range(0, 4095)));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_columns.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("proportional_font_column_generator_test: PASS");
    end else begin
      $display("proportional_font_column_generator_test: FAIL");
    end
    $finish;
  end

endmodule
